@@ design/cst_pkg.sv @@
// shared types, widths and codes for the cosine similarity threshold block
`default_nettype none

package cst_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int THR_W       = 16;
  localparam int COUNT_W     = 16;
  localparam int DOT_W       = 42;
  localparam int NORM_W      = 41;
  localparam int TSQ_W       = 31;
  localparam int MP_W        = 42;
  localparam int PROD_W      = 113;
  localparam int LHS_SHIFT   = 30;

  // operand selection for the shared bit-serial multiplier
  localparam logic [1:0] MUL_SQ   = 2'd0;
  localparam logic [1:0] MUL_NORM = 2'd1;
  localparam logic [1:0] MUL_THR  = 2'd2;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] left_value;
    logic signed [VALUE_WIDTH-1:0] right_value;
    logic                          last_element;
  } cst_in_t;

  typedef struct packed {
    logic               is_match;
    logic [COUNT_W-1:0] match_count;
  } cst_out_t;

  typedef struct packed {
    logic       acc_en;
    logic       snap;
    logic       mul_load;
    logic [1:0] mul_sel;
    logic       mul_step;
    logic       decide;
    logic       emit;
  } cst_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic slot_free;
  } cst_sts_t;

endpackage

`default_nettype wire

@@ design/cosine_similarity_threshold_core.sv @@
// top level of the streaming cosine similarity threshold block
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------------
//  in      | in  | in_valid / in_stall  | left_value, right_value, last_element
//  out     | out | out_valid / out_stall| is_match, match_count
//  cfg     | in  | cfg_valid / cfg_ready| similarity_threshold (signed q1.15)
//
// a pair without the last mark is accumulated directly: three 16x16 products
//   and saturating accumulate, then in_stall stays low
// a last pair starts a decision that holds in_stall high until the emit step,
//   for a span set by the one bit-serial shift-add multiplier (one bit a cycle)
//   and by out_stall
// the result waits in an output register; out_stall only delays the emit step
// rst is synchronous: clears accumulators, match count, output valid, and
//   loads the threshold with 0.5
`default_nettype none

module cosine_similarity_threshold_core
  import cst_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire cst_in_t                 in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output cst_out_t                     out_data,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic signed [THR_W-1:0] cfg_data
);

  cst_cmd_t cmd;
  cst_sts_t sts;

  // threshold register takes a request in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: accept, snapshot, three multiplies, compare, emit
  cst_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_data.last_element),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // accumulators, shared multiplier, exact compare and output register
  cst_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ design/cst_datapath.sv @@
// accumulators, bit-serial multiplier, compare and output register
`default_nettype none

module cst_datapath
  import cst_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cst_in_t                  in_data,
  input  wire logic                     cfg_write,
  input  wire logic signed [THR_W-1:0]  cfg_data,
  input  wire cst_cmd_t                 cmd,
  output cst_sts_t                      sts,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output cst_out_t                      out_data
);

  logic signed [THR_W-1:0]  similarity_threshold;
  logic signed [DOT_W-1:0]  dot_sum;
  logic [NORM_W-1:0]        left_norm_sum;
  logic [NORM_W-1:0]        right_norm_sum;
  logic [COUNT_W-1:0]       matches_seen;

  logic [NORM_W-1:0]        left_snap;
  logic [NORM_W-1:0]        right_snap;
  logic [TSQ_W-1:0]         tsq_snap;
  logic                     d_neg;
  logic                     d_zero;
  logic                     t_pos;

  logic [PROD_W-1:0]        mc;
  logic [MP_W-1:0]          mp;
  logic [PROD_W-1:0]        acc;
  logic [PROD_W-1:0]        lhs;
  logic                     match;

  // element products
  logic signed [2*VALUE_WIDTH-1:0] lr_prod;
  logic signed [2*VALUE_WIDTH-1:0] ll_prod;
  logic signed [2*VALUE_WIDTH-1:0] rr_prod;
  logic signed [DOT_W:0]           dot_wide;
  logic [NORM_W:0]                 left_wide;
  logic [NORM_W:0]                 right_wide;
  logic signed [DOT_W-1:0]         dot_next;
  logic [NORM_W-1:0]               left_next;
  logic [NORM_W-1:0]               right_next;

  logic [DOT_W-1:0]                d_mag;
  logic [THR_W-1:0]                t_mag;
  logic [2*THR_W-1:0]              t_sq_full;
  logic                            t_pos_now;
  logic                            norms_zero;
  logic                            match_next;
  logic [COUNT_W-1:0]              count_next;

  assign lr_prod = in_data.left_value * in_data.right_value;
  assign ll_prod = in_data.left_value * in_data.left_value;
  assign rr_prod = in_data.right_value * in_data.right_value;

  assign dot_wide   = (DOT_W+1)'(dot_sum) + (DOT_W+1)'(lr_prod);
  assign left_wide  = {1'b0, left_norm_sum} + (NORM_W+1)'(ll_prod[2*VALUE_WIDTH-2:0]);
  assign right_wide = {1'b0, right_norm_sum} + (NORM_W+1)'(rr_prod[2*VALUE_WIDTH-2:0]);

  // saturate instead of wrap on very long vectors
  always_comb begin
    if (dot_wide[DOT_W] != dot_wide[DOT_W-1]) begin
      dot_next = dot_wide[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
    end else begin
      dot_next = dot_wide[DOT_W-1:0];
    end
    left_next  = left_wide[NORM_W]  ? {NORM_W{1'b1}} : left_wide[NORM_W-1:0];
    right_next = right_wide[NORM_W] ? {NORM_W{1'b1}} : right_wide[NORM_W-1:0];
  end

  assign d_mag     = dot_sum[DOT_W-1] ? (~dot_sum + DOT_W'(1)) : dot_sum;
  assign t_mag     = similarity_threshold[THR_W-1] ?
                     (~similarity_threshold + THR_W'(1)) : similarity_threshold;
  assign t_sq_full = t_mag * t_mag;
  assign t_pos_now = !similarity_threshold[THR_W-1] && (similarity_threshold != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      similarity_threshold <= THR_W'(16384);
    end else if (cfg_write) begin
      similarity_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum        <= '0;
      left_norm_sum  <= '0;
      right_norm_sum <= '0;
    end else if (cmd.snap) begin
      dot_sum        <= '0;
      left_norm_sum  <= '0;
      right_norm_sum <= '0;
    end else if (cmd.acc_en) begin
      dot_sum        <= dot_next;
      left_norm_sum  <= left_next;
      right_norm_sum <= right_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      left_snap  <= left_norm_sum;
      right_snap <= right_norm_sum;
      tsq_snap   <= t_sq_full[TSQ_W-1:0];
      d_neg      <= dot_sum[DOT_W-1];
      d_zero     <= (dot_sum == '0);
      t_pos      <= t_pos_now;
    end
  end

  // shift-add multiplier, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      acc <= '0;
      case (cmd.mul_sel)
        MUL_SQ: begin
          mc <= PROD_W'(d_mag);
          mp <= d_mag;
        end
        MUL_NORM: begin
          mc <= PROD_W'(left_snap);
          mp <= MP_W'(right_snap);
        end
        default: begin
          mc <= acc;
          mp <= MP_W'(tsq_snap);
        end
      endcase
    end else if (cmd.mul_step) begin
      if (mp[0]) begin
        acc <= acc + mc;
      end
      mc <= mc << 1;
      mp <= mp >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load && (cmd.mul_sel == MUL_NORM)) begin
      lhs <= {acc[PROD_W-LHS_SHIFT-1:0], {LHS_SHIFT{1'b0}}};
    end
  end

  assign sts = {(mp == '0), (!out_valid || !out_stall)};

  // exact sign-case compare; acc now holds the threshold side
  assign norms_zero = (left_snap == '0) || (right_snap == '0);
  always_comb begin
    if (norms_zero) begin
      match_next = 1'b0;
    end else if (!t_pos && !d_neg) begin
      match_next = 1'b1;
    end else if (t_pos && (d_neg || d_zero)) begin
      match_next = 1'b0;
    end else if (t_pos) begin
      match_next = (lhs >= acc);
    end else begin
      match_next = (lhs <= acc);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      match <= match_next;
    end
  end

  assign count_next = (match && (matches_seen != {COUNT_W{1'b1}})) ?
                      matches_seen + COUNT_W'(1) : matches_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      matches_seen <= '0;
    end else if (cmd.emit) begin
      matches_seen <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.is_match    <= match;
      out_data.match_count <= count_next;
    end
  end

  a_snap_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.snap |=> (dot_sum == '0) && (left_norm_sum == '0) && (right_norm_sum == '0))
    else $error("accumulators not cleared after snapshot");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (matches_seen >= $past(matches_seen)))
    else $error("match count went down");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.slot_free)
    else $error("result emitted over a pending result");

endmodule

`default_nettype wire

@@ design/cst_controller.sv @@
// sequencer for accumulation, the three multiplies, compare and emit
`default_nettype none

module cst_controller
  import cst_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     in_last,
  output logic          in_stall,
  input  wire cst_sts_t sts,
  output cst_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_START    = 3'd1;
  localparam logic [2:0] S_MUL_SQ   = 3'd2;
  localparam logic [2:0] S_MUL_NORM = 3'd3;
  localparam logic [2:0] S_MUL_THR  = 3'd4;
  localparam logic [2:0] S_DECIDE   = 3'd5;
  localparam logic [2:0] S_EMIT     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.acc_en = in_valid;
        if (in_valid && in_last) begin
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.snap     = 1'b1;
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MUL_SQ;
        state_next   = S_MUL_SQ;
      end
      S_MUL_SQ: begin
        if (sts.mul_done) begin
          cmd.mul_load = 1'b1;
          cmd.mul_sel  = MUL_NORM;
          state_next   = S_MUL_NORM;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_MUL_NORM: begin
        if (sts.mul_done) begin
          cmd.mul_load = 1'b1;
          cmd.mul_sel  = MUL_THR;
          state_next   = S_MUL_THR;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_MUL_THR: begin
        if (sts.mul_done) begin
          state_next = S_DECIDE;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_last) |=> (state == S_START))
    else $error("last pair did not start a decision");

  a_emit_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !sts.slot_free) |=> (state == S_EMIT))
    else $error("left emit state with output slot busy");

endmodule

`default_nettype wire
